// ===== sv/tdp_pkg.sv =====
// Shared types and constants for the duration string parser.
// Used by the front end, the item queue, the back end and the top level.
`default_nettype none

package tdp_pkg;

  localparam int TotalW          = 64;
  localparam int PosW            = 8;
  localparam int QueueDepth      = 2;
  localparam int MaxCharsDefault = 256;

  localparam logic [TotalW-1:0] SecPerMin  = TotalW'(60);
  localparam logic [TotalW-1:0] MinPerHour = TotalW'(60);
  localparam logic [TotalW-1:0] HourPerDay = TotalW'(24);
  localparam logic [TotalW-1:0] DayPerWeek = TotalW'(7);
  localparam logic [TotalW-1:0] SecPerHour = SecPerMin * MinPerHour;
  localparam logic [TotalW-1:0] SecPerDay  = SecPerHour * HourPerDay;
  localparam logic [TotalW-1:0] SecPerWeek = SecPerDay * DayPerWeek;

  typedef enum logic [2:0] {
    CLS_SPACE,
    CLS_SIGN,
    CLS_UNIT,
    CLS_DIGIT,
    CLS_OTHER
  } char_cls_e;

  typedef enum logic [2:0] {
    MUL_ZERO,
    MUL_ONE,
    MUL_MIN,
    MUL_HOUR,
    MUL_DAY,
    MUL_WEEK
  } mul_e;

  typedef enum logic [1:0] {
    SIGN_NONE,
    SIGN_PLUS,
    SIGN_MINUS
  } sign_e;

  // One classified character as it travels from the front end to the back end.
  typedef struct packed {
    char_cls_e  cls;
    logic [3:0] digit;
    mul_e       unit;
    logic       minus;
    logic       last;
  } item_t;

  // What a result needs besides its value, carried alongside the arithmetic.
  typedef struct packed {
    logic            last;
    logic            neg;
    logic [PosW-1:0] pos;
    logic            complete;
  } res_meta_t;

endpackage

`default_nettype wire

// ===== sv/tdp_front.sv =====
// Front end of the duration string parser: input register and character classifier.
// Depends on tdp_pkg for the item type and class codes.
`default_nettype none

module tdp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    char_code_i,
  input  wire logic          last_char_i,
  output logic               item_valid_o,
  input  wire logic          item_ready_i,
  output tdp_pkg::item_t     item_o
);

  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] ChUpS   = 8'h53;
  localparam logic [7:0] ChLoS   = 8'h73;
  localparam logic [7:0] ChUpM   = 8'h4D;
  localparam logic [7:0] ChLoM   = 8'h6D;
  localparam logic [7:0] ChUpH   = 8'h48;
  localparam logic [7:0] ChLoH   = 8'h68;
  localparam logic [7:0] ChUpD   = 8'h44;
  localparam logic [7:0] ChLoD   = 8'h64;
  localparam logic [7:0] ChUpW   = 8'h57;
  localparam logic [7:0] ChLoW   = 8'h77;

  tdp_pkg::item_t item_d, item_q;
  logic           valid_q;

  always_comb begin
    item_d.cls   = tdp_pkg::CLS_OTHER;
    item_d.digit = char_code_i[3:0];
    item_d.unit  = tdp_pkg::MUL_ZERO;
    item_d.minus = (char_code_i == ChMinus);
    item_d.last  = last_char_i;
    case (char_code_i)
      ChSpace, ChTab: item_d.cls = tdp_pkg::CLS_SPACE;
      ChPlus, ChMinus: item_d.cls = tdp_pkg::CLS_SIGN;
      ChUpS, ChLoS: begin
        item_d.cls  = tdp_pkg::CLS_UNIT;
        item_d.unit = tdp_pkg::MUL_ONE;
      end
      ChUpM, ChLoM: begin
        item_d.cls  = tdp_pkg::CLS_UNIT;
        item_d.unit = tdp_pkg::MUL_MIN;
      end
      ChUpH, ChLoH: begin
        item_d.cls  = tdp_pkg::CLS_UNIT;
        item_d.unit = tdp_pkg::MUL_HOUR;
      end
      ChUpD, ChLoD: begin
        item_d.cls  = tdp_pkg::CLS_UNIT;
        item_d.unit = tdp_pkg::MUL_DAY;
      end
      ChUpW, ChLoW: begin
        item_d.cls  = tdp_pkg::CLS_UNIT;
        item_d.unit = tdp_pkg::MUL_WEEK;
      end
      default: begin
        if (char_code_i >= Ch0 && char_code_i <= Ch9) begin
          item_d.cls = tdp_pkg::CLS_DIGIT;
        end
      end
    endcase
  end

  assign in_ready_o   = !valid_q || item_ready_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/tdp_fifo.sv =====
// Short queue of classified items between the front end and the back end.
// Depends on tdp_pkg for the item type and the queue depth.
`default_nettype none

module tdp_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire tdp_pkg::item_t in_item_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output tdp_pkg::item_t     out_item_o
);

  localparam int Depth = tdp_pkg::QueueDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  tdp_pkg::item_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign in_ready_o  = (count_q != FullCnt);
  assign out_valid_o = (count_q != '0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/tdp_back.sv =====
// Back end of the duration string parser: parse state, unit product, total and result.
// Depends on tdp_pkg for item, metadata, code types and time constants.
`default_nettype none

module tdp_back #(
  parameter int MAX_CHARS = tdp_pkg::MaxCharsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         item_valid_i,
  output logic                              item_ready_o,
  input  wire tdp_pkg::item_t               item_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [tdp_pkg::TotalW-1:0]        total_seconds_o,
  output logic [tdp_pkg::PosW-1:0]          stop_position_o,
  output logic                              complete_o
);

  localparam int W      = tdp_pkg::TotalW;
  localparam int PW     = tdp_pkg::PosW;
  localparam int PosMax = (1 << PW) - 1;
  localparam int PosLimInt = (MAX_CHARS - 1 > PosMax) ? PosMax : MAX_CHARS - 1;
  localparam logic [PW-1:0] PosLim = PW'(PosLimInt);

  // Parse state, updated once per item taken from the queue.
  tdp_pkg::sign_e  sign_q, sign_d;
  logic [W-1:0]    acc_q, acc_d, acc_x10;
  logic            stopped_q, stopped_d;
  logic [PW-1:0]   pos_q, pos_d, stop_idx_q, stop_idx_d;
  logic [W-1:0]    opnd_d;
  tdp_pkg::mul_e   mul_d;
  tdp_pkg::res_meta_t meta_d;

  // Operand stage, product stage, result stage and output register.
  logic               a_valid_q;
  logic [W-1:0]       a_opnd_q;
  tdp_pkg::mul_e      a_mul_q;
  tdp_pkg::res_meta_t a_meta_q;

  logic               b_valid_q;
  logic [W-1:0]       b_prod_q, prod_d;
  tdp_pkg::res_meta_t b_meta_q;

  logic [W-1:0]       total_q, sum;

  logic               r_valid_q;
  logic [W-1:0]       r_sum_q;
  tdp_pkg::res_meta_t r_meta_q;

  logic               out_valid_q;
  logic [W-1:0]       out_total_q;
  logic [PW-1:0]      out_pos_q;
  logic               out_cmpl_q;

  logic out_free, r_go, r_free, b_go, b_free, a_go, a_free, f_go;

  assign out_free = !out_valid_q || out_ready_i;
  assign r_go     = r_valid_q && out_free;
  assign r_free   = !r_valid_q || out_free;
  assign b_go     = b_valid_q && (!b_meta_q.last || r_free);
  assign b_free   = !b_valid_q || b_go;
  assign a_go     = a_valid_q && b_free;
  assign a_free   = !a_valid_q || b_free;
  assign f_go     = item_valid_i && a_free;

  assign item_ready_o = a_free;

  always_comb begin
    acc_x10    = {acc_q[W-4:0], 3'b000} + {acc_q[W-2:0], 1'b0} + W'(item_i.digit);
    sign_d     = sign_q;
    acc_d      = acc_q;
    stopped_d  = stopped_q;
    stop_idx_d = stop_idx_q;
    opnd_d     = '0;
    mul_d      = tdp_pkg::MUL_ZERO;
    if (!stopped_q) begin
      case (item_i.cls)
        tdp_pkg::CLS_SIGN: begin
          if (sign_q == tdp_pkg::SIGN_NONE) begin
            sign_d = item_i.minus ? tdp_pkg::SIGN_MINUS : tdp_pkg::SIGN_PLUS;
          end else begin
            // A second sign stops without adding the pending digits.
            stopped_d  = 1'b1;
            stop_idx_d = pos_q;
          end
        end
        tdp_pkg::CLS_UNIT: begin
          opnd_d = acc_q;
          mul_d  = item_i.unit;
          acc_d  = '0;
        end
        tdp_pkg::CLS_DIGIT: acc_d = acc_x10;
        tdp_pkg::CLS_OTHER: begin
          opnd_d     = acc_q;
          mul_d      = tdp_pkg::MUL_ONE;
          stopped_d  = 1'b1;
          stop_idx_d = pos_q;
        end
        default: ;
      endcase
    end
    pos_d = (pos_q < PosLim) ? pos_q + PW'(1) : pos_q;
    // On the final character of an unstopped string the pending digits count as seconds.
    // A unit letter has already cleared them and claimed the product slot.
    if (item_i.last && !stopped_d && item_i.cls != tdp_pkg::CLS_UNIT) begin
      opnd_d = acc_d;
      mul_d  = tdp_pkg::MUL_ONE;
    end
    meta_d.last     = item_i.last;
    meta_d.neg      = (sign_d == tdp_pkg::SIGN_MINUS);
    meta_d.pos      = stopped_d ? stop_idx_d : pos_d;
    meta_d.complete = !stopped_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sign_q     <= tdp_pkg::SIGN_NONE;
      acc_q      <= '0;
      stopped_q  <= 1'b0;
      pos_q      <= '0;
      stop_idx_q <= '0;
    end else if (f_go) begin
      if (item_i.last) begin
        sign_q     <= tdp_pkg::SIGN_NONE;
        acc_q      <= '0;
        stopped_q  <= 1'b0;
        pos_q      <= '0;
        stop_idx_q <= '0;
      end else begin
        sign_q     <= sign_d;
        acc_q      <= acc_d;
        stopped_q  <= stopped_d;
        pos_q      <= pos_d;
        stop_idx_q <= stop_idx_d;
      end
    end
  end

  always_comb begin
    case (a_mul_q)
      tdp_pkg::MUL_ONE:  prod_d = a_opnd_q;
      tdp_pkg::MUL_MIN:  prod_d = a_opnd_q * tdp_pkg::SecPerMin;
      tdp_pkg::MUL_HOUR: prod_d = a_opnd_q * tdp_pkg::SecPerHour;
      tdp_pkg::MUL_DAY:  prod_d = a_opnd_q * tdp_pkg::SecPerDay;
      tdp_pkg::MUL_WEEK: prod_d = a_opnd_q * tdp_pkg::SecPerWeek;
      default:           prod_d = '0;
    endcase
  end

  // After a stop every product is zero, so the total freezes at the stop value.
  assign sum = total_q + b_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      r_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      if (a_free) begin
        a_valid_q <= item_valid_i;
      end
      if (b_free) begin
        b_valid_q <= a_valid_q;
      end
      if (r_free) begin
        r_valid_q <= b_go && b_meta_q.last;
      end
      if (out_free) begin
        out_valid_q <= r_valid_q;
      end
      if (b_go) begin
        total_q <= b_meta_q.last ? '0 : sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_go) begin
      a_opnd_q <= opnd_d;
      a_mul_q  <= mul_d;
      a_meta_q <= meta_d;
    end
    if (a_go) begin
      b_prod_q <= prod_d;
      b_meta_q <= a_meta_q;
    end
    if (b_go && b_meta_q.last) begin
      r_sum_q  <= sum;
      r_meta_q <= b_meta_q;
    end
    if (r_go) begin
      out_total_q <= r_meta_q.neg ? (~r_sum_q + W'(1)) : r_sum_q;
      out_pos_q   <= r_meta_q.pos;
      out_cmpl_q  <= r_meta_q.complete;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign total_seconds_o = out_total_q;
  assign stop_position_o = out_pos_q;
  assign complete_o      = out_cmpl_q;

  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q && !(f_go && item_i.last) |=> stopped_q)
    else $error("parse stop flag cleared before the end of the string");

  a_pos_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosLim)
    else $error("character position beyond its saturation limit");

  a_stopped_no_product: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_go && stopped_q |=> a_valid_q && a_mul_q == tdp_pkg::MUL_ZERO)
    else $error("item after a stop produced a nonzero product");

  a_total_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_go && b_meta_q.last |=> total_q == '0)
    else $error("running total not cleared after the final character");

endmodule

`default_nettype wire

// ===== sv/ttl_duration_parser.sv =====
// Duration string parser, one character per item.
//
// The input channel (in_valid_i / in_ready_o) carries one ASCII character
// per item in char_code_i, with last_char_i set on the final character of a
// string. Digits, unit letters (s, m, h, d, w in either case), spaces, tabs
// and one sign anywhere are understood; a second sign or anything else ends the parse early.
// The output channel (out_valid_o / out_ready_i) carries one result per
// string: the signed total in seconds, the position where parsing stopped
// (or the string length, saturated) and a flag that is set when the whole
// string was consumed.
// Throughput is one character per cycle, sustained while the receiver takes results.
// A result is offered once its final character has passed the input register,
// then the queue, parse-state, unit-product, total and output stages.
// Reset empties every stage and clears the parse state. When the receiver
// holds off, finished results wait in the output and result registers and
// the queue fills before in_ready_o falls; nothing is lost or repeated.
// Depends on tdp_pkg, tdp_front, tdp_fifo and tdp_back.
`default_nettype none

module ttl_duration_parser #(
  parameter int MAX_CHARS = tdp_pkg::MaxCharsDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [7:0]                  char_code_i,
  input  wire logic                        last_char_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic signed [tdp_pkg::TotalW-1:0] total_seconds_o,
  output logic [tdp_pkg::PosW-1:0]         stop_position_o,
  output logic                             complete_o
);

  tdp_pkg::item_t front_item, queue_item;
  logic           front_valid, front_ready;
  logic           queue_valid, queue_ready;
  logic [tdp_pkg::TotalW-1:0] total_raw;

  tdp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_code_i  (char_code_i),
    .last_char_i  (last_char_i),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready),
    .item_o       (front_item)
  );

  tdp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_item_i   (front_item),
    .out_valid_o (queue_valid),
    .out_ready_i (queue_ready),
    .out_item_o  (queue_item)
  );

  tdp_back #(
    .MAX_CHARS (MAX_CHARS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (queue_valid),
    .item_ready_o    (queue_ready),
    .item_i          (queue_item),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .total_seconds_o (total_raw),
    .stop_position_o (stop_position_o),
    .complete_o      (complete_o)
  );

  assign total_seconds_o = $signed(total_raw);

endmodule

`default_nettype wire
